/* hdl/tchd_pkg.sv */
package tchd_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   // Remainder / divisor width: holds the divisor up to TABLE_DEPTH itself
   localparam int DIV_W       = ADDR_W + 1;

   // Field widths
   localparam int ID_W   = 31;
   localparam int COST_W = 31;
   localparam int SIZE_W = 11;
   localparam int IDX_W  = $clog2(ID_W);

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

   // Operation codes
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // One table entry
   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   node_id;
      logic [COST_W-1:0] cost_g;
      logic [COST_W-1:0] score_f;
   } slot_type;

endpackage

/* hdl/two_choice_hash_dedup_table.sv */
// Flow: a req_ transfer reaches rsp_valid through two 31-step mod passes
//   on the shared restoring divider, two table reads and a decide/write state.
// Items: one in work at a time; the single divider and the one table
//   carry each item alone, and a finished result may wait while the next is taken.
// Reset: synchronous; then a clearing pass over all TABLE_DEPTH (1024) entries
//   empties the table with req_ready low. The size register resets to 1024.
module two_choice_hash_dedup_table import tchd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [ID_W-1:0]   req_node_id,
   input  logic [COST_W-1:0] req_cost_g,
   input  logic [COST_W-1:0] req_score_f,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_keep,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_table_size
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV0  = 3'd2;
   localparam logic [2:0] ST_DIV1  = 3'd3;
   localparam logic [2:0] ST_RD0   = 3'd4;
   localparam logic [2:0] ST_RD1   = 3'd5;
   localparam logic [2:0] ST_DEC   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [SIZE_W-1:0] table_size_ff;
   logic              kind_ff, kind_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic [COST_W-1:0] score_ff, score_in;
   logic [IDX_W-1:0]  bit_idx_ff, bit_idx_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [ADDR_W-1:0] h0_ff, h0_in;
   logic [ADDR_W-1:0] h1_ff, h1_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   slot_type          slot0_ff;
   slot_type          rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_keep_ff, rsp_keep_in;

   logic [DIV_W-1:0]  eff_size;
   logic [DIV_W-1:0]  divisor;
   logic [DIV_W-1:0]  rem_shift;
   logic [DIV_W-1:0]  rem_next;
   logic              out_free;
   logic              hold0, hold1, ok0, ok1, use1, same, dup, drop, keep;
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   slot_type          wr_data;
   slot_type          mem [TABLE_DEPTH];

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_keep  = rsp_keep_ff;

   // Size register
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= SIZE_RESET;
      end else if (csr_valid) begin
         table_size_ff <= csr_table_size;
      end
   end

   // Saturate the size into 2..TABLE_DEPTH
   always_comb begin
      if (table_size_ff < SIZE_W'(2)) begin
         eff_size = DIV_W'(2);
      end else if (int'(table_size_ff) > TABLE_DEPTH) begin
         eff_size = DIV_W'(TABLE_DEPTH);
      end else begin
         eff_size = DIV_W'(table_size_ff);
      end
   end

   // Shared restoring divider step, one dividend bit per cycle
   assign divisor   = (state_ff == ST_DIV1) ? eff_size - DIV_W'(1) : eff_size;
   assign rem_shift = {rem_ff[DIV_W-2:0], id_ff[bit_idx_ff]};
   assign rem_next  = (rem_shift >= divisor) ? rem_shift - divisor : rem_shift;

   // Decision from the two candidate slots (slot 1 sits in the read register)
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hold0    = slot0_ff.valid && (slot0_ff.node_id == id_ff);
   assign hold1    = rd_data_ff.valid && (rd_data_ff.node_id == id_ff);
   assign ok0      = hold0 || !slot0_ff.valid;
   assign ok1      = hold1 || !rd_data_ff.valid;
   assign use1     = !ok0 && ok1;
   assign same     = (h0_ff == h1_ff);
   assign dup      = use1 ? (hold1 || (!same && hold0)) : (hold0 || (!same && hold1));
   assign drop     = (hold0 && (slot0_ff.cost_g < cost_ff))
                   || (hold1 && (rd_data_ff.cost_g < cost_ff));
   assign keep     = (kind_ff == KIND_INSERT) ? !dup : !drop;

   // Table port control
   always_comb begin
      rd_en   = (state_ff == ST_RD0) || (state_ff == ST_RD1);
      rd_addr = (state_ff == ST_RD0) ? h0_ff : h1_ff;
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
      end else if ((state_ff == ST_DEC) && out_free && (kind_ff == KIND_INSERT)) begin
         wr_en           = 1'b1;
         wr_addr         = use1 ? h1_ff : h0_ff;
         wr_data.valid   = 1'b1;
         wr_data.node_id = id_ff;
         wr_data.cost_g  = cost_ff;
         wr_data.score_f = score_ff;
      end
   end

   // Slot table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      cost_in      = cost_ff;
      score_in     = score_ff;
      bit_idx_in   = bit_idx_ff;
      rem_in       = rem_ff;
      h0_in        = h0_ff;
      h1_in        = h1_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_keep_in  = rsp_keep_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in    = req_kind;
               id_in      = req_node_id;
               cost_in    = req_cost_g;
               score_in   = req_score_f;
               bit_idx_in = IDX_W'(ID_W - 1);
               rem_in     = '0;
               state_in   = ST_DIV0;
            end
         end
         ST_DIV0: begin
            rem_in     = rem_next;
            bit_idx_in = bit_idx_ff - IDX_W'(1);
            if (bit_idx_ff == '0) begin
               h0_in      = rem_next[ADDR_W-1:0];
               rem_in     = '0;
               bit_idx_in = IDX_W'(ID_W - 1);
               state_in   = ST_DIV1;
            end
         end
         ST_DIV1: begin
            rem_in     = rem_next;
            bit_idx_in = bit_idx_ff - IDX_W'(1);
            if (bit_idx_ff == '0) begin
               h1_in    = rem_next[ADDR_W-1:0] + ADDR_W'(1);
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            state_in = ST_RD1;
         end
         ST_RD1: begin
            state_in = ST_DEC;
         end
         ST_DEC: begin
            // wait until the result register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_keep_in  = keep;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      cost_ff     <= cost_in;
      score_ff    <= score_in;
      bit_idx_ff  <= bit_idx_in;
      rem_ff      <= rem_in;
      h0_ff       <= h0_in;
      h1_ff       <= h1_in;
      rsp_keep_ff <= rsp_keep_in;
      if (state_ff == ST_RD1) begin
         slot0_ff <= rd_data_ff;
      end
   end

endmodule

/* hdl/tchd_checker.sv */
module tchd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_keep
);

   // Items taken but not yet answered
   logic [1:0] pend_ff, pend_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_xfer && !rsp_xfer) begin
         pend_in = pend_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A result waiting for transfer stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_keep))
      else $error("rsp dropped or changed while stalled");

   // No result without an outstanding item
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("rsp without a matching req transfer");

   // At most one item in work beside one waiting result
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == 2'd2) |-> !req_ready)
      else $error("req taken with two items outstanding");

   // One item at a time: busy straight after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("req_ready high right after a transfer");

   // Clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("block not in clearing pass after reset");

endmodule

bind two_choice_hash_dedup_table tchd_checker u_tchd_checker (.*);
